### hw/rtl/rmsp_pkg.sv
// shared types, constants and arithmetic helpers for the rmsprop update block
package rmsp_pkg;

	localparam int STATE_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(STATE_DEPTH);
	localparam int SQRT_STAGES = 32;
	localparam int DIV_STAGES  = 55;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 24;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_STEP_SIZE        = 3'd0,
		REG_DECAY_RATE       = 3'd1,
		REG_STABILITY_OFFSET = 3'd2,
		REG_L2_COEFF         = 3'd3,
		REG_CENTERED_MODE    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [23:0] step_size;
		logic [15:0] decay_rate;
		logic [15:0] stability_offset;
		logic [15:0] l2_coeff;
		logic        centered_mode;
	} cfg_t;

	// element travelling alongside the root computation
	typedef struct packed {
		logic [11:0]        idx;
		logic signed [31:0] p;
		logic signed [31:0] gd;
	} side_t;

	// element travelling alongside the divider
	typedef struct packed {
		logic [11:0]        idx;
		logic signed [31:0] p;
		logic               neg;
	} div_side_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sh0000_0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (x < -64'sh0000_0000_8000_0000)
			r = -32'sh8000_0000;
		else
			r = x[31:0];
		return r;
	endfunction

	// floor(v * f / 2^16), split into a high and a low partial product
	function automatic logic [63:0] mul_frac(input logic [63:0] v, input logic [16:0] f);
		logic [63:0] hi;
		logic [32:0] lo;
		hi = {16'b0, v[63:16]} * {47'b0, f};
		lo = {17'b0, v[15:0]} * {16'b0, f};
		return hi + {47'b0, lo[32:16]};
	endfunction

endpackage

### hw/rtl/rmsp_update.sv
// state memories, read-modify-write of the running averages and variance
module rmsp_update (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  rmsp_pkg::cfg_t       cfg,
	input  logic                 in_valid,
	input  logic [11:0]          in_idx,
	input  logic signed [31:0]   in_p,
	input  logic signed [31:0]   in_g,
	output logic                 clr_busy,
	output logic                 out_valid,
	output rmsp_pkg::side_t      out_side,
	output logic [63:0]          out_var
);
	import rmsp_pkg::*;

	logic [63:0] sq_mem [STATE_DEPTH];
	logic [31:0] ga_mem [STATE_DEPTH];
	logic [63:0] sq_rd_q;
	logic [31:0] ga_rd_q;

	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_cnt_q;

	logic [16:0] a17, b17;
	assign a17 = {1'b0, cfg.decay_rate};
	assign b17 = 17'd65536 - a17;

	// stage registers
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [11:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6, idx_s7;
	logic signed [31:0] p_s1, p_s2, p_s3, p_s4, p_s5, p_s6, p_s7;
	logic signed [31:0] g_s1, g_s2;
	logic signed [48:0] wdp_s2;
	logic signed [31:0] gd_s3, gd_s4, gd_s5, gd_s6, gd_s7;
	logic [63:0]        g2_s4;
	logic signed [49:0] gdb_s4, gdb_s5;
	logic [63:0]        g2b_s5;
	logic [63:0]        sq_s6, sq_s7;
	logic signed [31:0] ga_s6;
	logic [63:0]        ga2_s7;

	// carried state values, kept current by forwarding
	logic        hit_sq_s1, hit_ga_s1;
	logic [63:0] fwd_sq_s1;
	logic [31:0] fwd_ga_s1;
	logic [63:0] sq_s2, sq_s3, sq_s4, sq_s5;
	logic [31:0] ga_s2, ga_s3, ga_s4, ga_s5;

	logic [63:0] sq_eff_s1;
	logic [31:0] ga_eff_s1;
	assign sq_eff_s1 = hit_sq_s1 ? fwd_sq_s1 : sq_rd_q;
	assign ga_eff_s1 = hit_ga_s1 ? fwd_ga_s1 : ga_rd_q;

	// arithmetic
	logic signed [48:0] wdp;
	logic signed [33:0] gsum;
	logic signed [31:0] gd;
	logic signed [63:0] g2_full;
	logic signed [49:0] gdb;
	logic [63:0]        g2b;
	logic [63:0]        sq_new;
	logic signed [48:0] gaa;
	logic signed [50:0] gasum;
	logic signed [31:0] ga_new;
	logic signed [63:0] ga2_full;

	assign wdp      = $signed({1'b0, cfg.l2_coeff}) * p_s1;
	assign gsum     = 34'(g_s2) + 34'(wdp_s2 >>> 16);
	assign gd       = sat32(64'(gsum));
	assign g2_full  = gd_s3 * gd_s3;
	assign gdb      = gd_s3 * $signed({1'b0, b17});
	assign g2b      = mul_frac(g2_s4, b17);
	assign sq_new   = mul_frac(sq_s5, a17) + g2b_s5;
	assign gaa      = $signed(ga_s5) * $signed(a17);
	assign gasum    = 51'(gaa) + 51'(gdb_s5);
	assign ga_new   = sat32(64'(gasum >>> 16));
	assign ga2_full = ga_s6 * ga_s6;

	// write port: clearing pass or the write-back of stage 5
	logic              wr_sq, wr_ga;
	logic [ADDR_W-1:0] wr_addr;
	logic [63:0]       wr_sq_data;
	logic [31:0]       wr_ga_data;

	assign wr_sq      = clr_busy_q | (en & v_s5);
	assign wr_ga      = clr_busy_q | (en & v_s5 & cfg.centered_mode);
	assign wr_addr    = clr_busy_q ? clr_cnt_q : idx_s5[ADDR_W-1:0];
	assign wr_sq_data = clr_busy_q ? '0 : sq_new;
	assign wr_ga_data = clr_busy_q ? '0 : ga_new;

	logic pipe_sq, pipe_ga;
	assign pipe_sq = en & v_s5;
	assign pipe_ga = en & v_s5 & cfg.centered_mode;

	always_ff @(posedge clk) begin
		if (wr_sq)
			sq_mem[wr_addr] <= wr_sq_data;
		if (en)
			sq_rd_q <= sq_mem[in_idx[ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wr_ga)
			ga_mem[wr_addr] <= wr_ga_data;
		if (en)
			ga_rd_q <= ga_mem[in_idx[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == ADDR_W'(STATE_DEPTH - 1))
				clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	function automatic logic same(input logic [11:0] x, input logic [11:0] y);
		return x[ADDR_W-1:0] == y[ADDR_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1 <= in_idx;
			p_s1   <= in_p;
			g_s1   <= in_g;
			// write in the same cycle as the read: memory returns old data
			hit_sq_s1 <= pipe_sq & same(idx_s5, in_idx);
			hit_ga_s1 <= pipe_ga & same(idx_s5, in_idx);
			fwd_sq_s1 <= sq_new;
			fwd_ga_s1 <= ga_new;

			idx_s2 <= idx_s1;
			p_s2   <= p_s1;
			g_s2   <= g_s1;
			wdp_s2 <= wdp;
			sq_s2  <= (pipe_sq & same(idx_s5, idx_s1)) ? sq_new : sq_eff_s1;
			ga_s2  <= (pipe_ga & same(idx_s5, idx_s1)) ? ga_new : ga_eff_s1;

			idx_s3 <= idx_s2;
			p_s3   <= p_s2;
			gd_s3  <= gd;
			sq_s3  <= (pipe_sq & same(idx_s5, idx_s2)) ? sq_new : sq_s2;
			ga_s3  <= (pipe_ga & same(idx_s5, idx_s2)) ? ga_new : ga_s2;

			idx_s4 <= idx_s3;
			p_s4   <= p_s3;
			gd_s4  <= gd_s3;
			g2_s4  <= g2_full;
			gdb_s4 <= gdb;
			sq_s4  <= (pipe_sq & same(idx_s5, idx_s3)) ? sq_new : sq_s3;
			ga_s4  <= (pipe_ga & same(idx_s5, idx_s3)) ? ga_new : ga_s3;

			idx_s5 <= idx_s4;
			p_s5   <= p_s4;
			gd_s5  <= gd_s4;
			g2b_s5 <= g2b;
			gdb_s5 <= gdb_s4;
			sq_s5  <= (pipe_sq & same(idx_s5, idx_s4)) ? sq_new : sq_s4;
			ga_s5  <= (pipe_ga & same(idx_s5, idx_s4)) ? ga_new : ga_s4;

			idx_s6 <= idx_s5;
			p_s6   <= p_s5;
			gd_s6  <= gd_s5;
			sq_s6  <= sq_new;
			ga_s6  <= ga_new;

			idx_s7 <= idx_s6;
			p_s7   <= p_s6;
			gd_s7  <= gd_s6;
			sq_s7  <= sq_s6;
			ga2_s7 <= ga2_full;
		end
	end

	always_comb begin
		if (!cfg.centered_mode)
			out_var = sq_s7;
		else if (sq_s7 > ga2_s7)
			out_var = sq_s7 - ga2_s7;
		else
			out_var = '0;
	end

	assign clr_busy     = clr_busy_q;
	assign out_valid    = v_s7;
	assign out_side.idx = idx_s7;
	assign out_side.p   = p_s7;
	assign out_side.gd  = gd_s7;

endmodule

### hw/rtl/rmsp_sqrt.sv
// pipelined integer square root, one result bit per stage
module rmsp_sqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  rmsp_pkg::side_t in_side,
	input  logic [63:0]     in_var,
	output logic            out_valid,
	output rmsp_pkg::side_t out_side,
	output logic [31:0]     out_root
);
	import rmsp_pkg::*;

	logic [63:0] x_q [SQRT_STAGES];
	logic [63:0] r_q [SQRT_STAGES];
	side_t       s_q [SQRT_STAGES];
	logic        v_q [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		localparam logic [63:0] BITK = 64'd1 << (62 - 2 * k);
		logic [63:0] xi, ri, xo, ro, tr;
		side_t       si;
		logic        vi;

		if (k == 0) begin : g_first
			assign xi = in_var;
			assign ri = '0;
			assign si = in_side;
			assign vi = in_valid;
		end else begin : g_next
			assign xi = x_q[k-1];
			assign ri = r_q[k-1];
			assign si = s_q[k-1];
			assign vi = v_q[k-1];
		end

		always_comb begin
			tr = ri + BITK;
			if (xi >= tr) begin
				xo = xi - tr;
				ro = (ri >> 1) + BITK;
			end else begin
				xo = xi;
				ro = ri >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_q[k] <= 1'b0;
			else if (en)
				v_q[k] <= vi;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_q[k] <= xo;
				r_q[k] <= ro;
				s_q[k] <= si;
			end
		end
	end

	assign out_valid = v_q[SQRT_STAGES-1];
	assign out_side  = s_q[SQRT_STAGES-1];
	assign out_root  = r_q[SQRT_STAGES-1][31:0];

endmodule

### hw/rtl/rmsp_div.sv
// pipelined restoring divider for the step magnitude, one quotient bit per stage
module rmsp_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  rmsp_pkg::div_side_t in_side,
	input  logic [54:0]         in_num,
	input  logic [40:0]         in_den,
	output logic                out_valid,
	output rmsp_pkg::div_side_t out_side,
	output logic [54:0]         out_quo
);
	import rmsp_pkg::*;

	logic [40:0] rem_q [DIV_STAGES];
	logic [54:0] nq_q  [DIV_STAGES];
	logic [40:0] d_q   [DIV_STAGES];
	div_side_t   s_q   [DIV_STAGES];
	logic        v_q   [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [40:0] remi, remo, di;
		logic [54:0] nqi, nqo;
		logic [41:0] sh;
		div_side_t   si;
		logic        vi;

		if (k == 0) begin : g_first
			assign remi = '0;
			assign nqi  = in_num;
			assign di   = in_den;
			assign si   = in_side;
			assign vi   = in_valid;
		end else begin : g_next
			assign remi = rem_q[k-1];
			assign nqi  = nq_q[k-1];
			assign di   = d_q[k-1];
			assign si   = s_q[k-1];
			assign vi   = v_q[k-1];
		end

		always_comb begin
			sh = {remi, nqi[54]};
			if (sh >= {1'b0, di}) begin
				remo = 41'(sh - {1'b0, di});
				nqo  = {nqi[53:0], 1'b1};
			end else begin
				remo = sh[40:0];
				nqo  = {nqi[53:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_q[k] <= 1'b0;
			else if (en)
				v_q[k] <= vi;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= remo;
				nq_q[k]  <= nqo;
				d_q[k]   <= di;
				s_q[k]   <= si;
			end
		end
	end

	assign out_valid = v_q[DIV_STAGES-1];
	assign out_side  = s_q[DIV_STAGES-1];
	assign out_quo   = nq_q[DIV_STAGES-1];

endmodule

### hw/rtl/rmsprop_parameter_update.sv
// top level of the rmsprop parameter update block
// One element beat per clock in, one result beat per clock out while m_tready
// does not stall the output. A beat runs through 7 stages of state read,
// weight decay and running-average update, 32 square-root stages, one stage
// for the denominator and the step product, 55 divider stages and the output
// register. Both running averages live in 4096-entry synchronous memories that
// are read when a beat is accepted and written back in stage 5; a beat that
// follows a beat to the same element gets the fresh value by forwarding, so
// any index pattern runs at full rate. After reset a clearing pass zeroes the
// memories entry by entry, during which s_tready stays low; configuration
// writes are taken at any time. The whole pipeline advances whenever the
// output register is empty or being read, so a stall on m_tready holds every
// stage in place.
module rmsprop_parameter_update (
	input  logic                               clk,
	input  logic                               arst_n,
	// input beat
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [79:0]                        s_tdata,   // element_index, param_value, grad_value
	// result beat
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [47:0]                        m_tdata,   // result_index, new_param_value
	// configuration writes
	input  logic                               cfg_we,
	input  logic [rmsp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [rmsp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import rmsp_pkg::*;

	// configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_size        <= 24'd167772;
			cfg_q.decay_rate       <= 16'd65208;
			cfg_q.stability_offset <= 16'd1;
			cfg_q.l2_coeff         <= 16'd0;
			cfg_q.centered_mode    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_STEP_SIZE:        cfg_q.step_size        <= cfg_wdata;
				REG_DECAY_RATE:       cfg_q.decay_rate       <= cfg_wdata[15:0];
				REG_STABILITY_OFFSET: cfg_q.stability_offset <= cfg_wdata[15:0];
				REG_L2_COEFF:         cfg_q.l2_coeff         <= cfg_wdata[15:0];
				REG_CENTERED_MODE:    cfg_q.centered_mode    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// global advance: output register free or being drained
	logic en;
	logic clr_busy;
	assign en       = ~m_tvalid | m_tready;
	assign s_tready = en & ~clr_busy;

	// state update and variance
	logic        upd_valid;
	side_t       upd_side;
	logic [63:0] upd_var;

	rmsp_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid & ~clr_busy),
		.in_idx    (s_tdata[11:0]),
		.in_p      (s_tdata[43:12]),
		.in_g      (s_tdata[75:44]),
		.clr_busy  (clr_busy),
		.out_valid (upd_valid),
		.out_side  (upd_side),
		.out_var   (upd_var)
	);

	// root of the variance
	logic        sq_valid;
	side_t       sq_side;
	logic [31:0] sq_root;

	rmsp_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (upd_valid),
		.in_side   (upd_side),
		.in_var    (upd_var),
		.out_valid (sq_valid),
		.out_side  (sq_side),
		.out_root  (sq_root)
	);

	// denominator and step numerator
	logic signed [56:0] prod;
	logic [32:0]        den;
	assign prod = $signed({1'b0, cfg_q.step_size}) * sq_side.gd;

	always_comb begin
		den = 33'(sq_root) + 33'(cfg_q.stability_offset);
		// zero root and zero epsilon: one lsb
		if (den == '0)
			den = 33'd1;
	end

	logic               v_t1;
	logic signed [56:0] prod_t1;
	logic [32:0]        den_t1;
	logic [11:0]        idx_t1;
	logic signed [31:0] p_t1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_t1 <= 1'b0;
		else if (en)
			v_t1 <= sq_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_t1 <= prod;
			den_t1  <= den;
			idx_t1  <= sq_side.idx;
			p_t1    <= sq_side.p;
		end
	end

	div_side_t   dv_in_side;
	logic [54:0] num_mag;
	assign num_mag        = prod_t1[56] ? 55'(-prod_t1) : 55'(prod_t1);
	assign dv_in_side.idx = idx_t1;
	assign dv_in_side.p   = p_t1;
	assign dv_in_side.neg = prod_t1[56];

	logic        dv_valid;
	div_side_t   dv_side;
	logic [54:0] dv_quo;

	rmsp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_t1),
		.in_side   (dv_in_side),
		.in_num    (num_mag),
		.in_den    ({den_t1, 8'b0}),
		.out_valid (dv_valid),
		.out_side  (dv_side),
		.out_quo   (dv_quo)
	);

	// quotient truncated toward zero, then saturated subtract
	logic signed [56:0] step;
	logic signed [57:0] diff;
	logic signed [31:0] res;
	assign step = dv_side.neg ? -$signed({2'b0, dv_quo}) : $signed({2'b0, dv_quo});
	assign diff = 58'(dv_side.p) - 58'(step);
	assign res  = sat32(64'(diff));

	// output register
	logic        m_valid_q;
	logic [47:0] m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (en)
			m_valid_q <= dv_valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			m_data_q <= {4'b0, res, dv_side.idx};
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
